// ===== design/rht_pkg.sv =====
// Package for the reference-counted handle table.
// Holds the field widths, the command codes and the packet that walks the cell chain.
// No dependencies.
package rht_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned TypeW    = 5;
  localparam int unsigned CreatorW = 16;
  localparam int unsigned IdW      = 32;
  localparam int unsigned RefsW    = 16;

  localparam int unsigned DefaultEntries = 16;

  localparam logic [CmdW-1:0] CmdCreate = 2'd0;
  localparam logic [CmdW-1:0] CmdAttach = 2'd1;
  localparam logic [CmdW-1:0] CmdDetach = 2'd2;

  localparam logic [RefsW-1:0] RefsMax = {RefsW{1'b1}};
  localparam logic [RefsW-1:0] RefsOne = {{(RefsW-1){1'b0}}, 1'b1};

  // Command packet handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic                valid;
    logic                done;      // some cell upstream already served it
    logic [CmdW-1:0]     cmd;
    logic [TypeW-1:0]    ns_type;
    logic [CreatorW-1:0] creator;
    logic [IdW-1:0]      target_id;
  } pkt_t;

endpackage

// ===== design/refcounted_handle_table.sv =====
// Reference-counted handle table: input register, a chain of slot cells, id counter.
// Depends on rht_pkg and rht_cell.
//
// A command is taken at a clock edge with start_i high and busy_o low. It then walks
// the row of slot cells, one cell per cycle; the first cell that can serve it does so.
// The result is on status_o and new_id_o for exactly one cycle with result_valid_o
// high, after the launch register and the register of every cell, and the receiver
// cannot hold it off. busy_o drops in that same strobe cycle, so a new command can be
// taken at its end; no command is taken while the last one is still in the cells.
// No clearing pass is needed after reset.
module refcounted_handle_table
  import rht_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DefaultEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [TypeW-1:0]    ns_type_i,
  input  logic [CreatorW-1:0] creator_i,
  input  logic [IdW-1:0]      target_id_i,
  output logic                result_valid_o,
  output logic                status_o,
  output logic [IdW-1:0]      new_id_o
);

  pkt_t           pkt [TABLE_ENTRIES+1];
  pkt_t           pkt0_q, pkt0_d;
  logic           busy_q, busy_d;
  logic [IdW-1:0] next_id_q, next_id_d;
  logic           accept;
  logic           create_ok;
  pkt_t           last;

  assign accept = start_i && !busy_q;
  assign last   = pkt[TABLE_ENTRIES];

  // Launch register in front of the chain
  always_comb begin
    pkt0_d.valid     = accept;
    pkt0_d.done      = 1'b0;
    pkt0_d.cmd       = cmd_i;
    pkt0_d.ns_type   = ns_type_i;
    pkt0_d.creator   = creator_i;
    pkt0_d.target_id = target_id_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt0_q <= '0;
    end else begin
      pkt0_q <= pkt0_d;
    end
  end

  assign pkt[0] = pkt0_q;

  // Row of slot cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rht_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .next_id_i (next_id_q),
      .pkt_i     (pkt[g]),
      .pkt_o     (pkt[g+1])
    );
  end

  // Busy from the transfer until the packet enters the last cell's register
  always_comb begin
    busy_d = busy_q;
    if (accept) busy_d = 1'b1;
    else if (pkt[TABLE_ENTRIES-1].valid) busy_d = 1'b0;
  end

  // Id counter advances on a successful create, as its result goes out
  assign create_ok = last.valid && last.done && (last.cmd == CmdCreate);
  assign next_id_d = create_ok ? next_id_q + IdW'(1) : next_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      next_id_q <= IdW'(1);
    end else begin
      busy_q    <= busy_d;
      next_id_q <= next_id_d;
    end
  end

  assign busy_o         = busy_q;
  assign result_valid_o = last.valid;
  assign status_o       = !last.done;
  assign new_id_o       = create_ok ? next_id_q : '0;

`ifndef ASSERT_OFF
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("busy not raised after command transfer");

  a_result_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("result strobe while busy");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe held two cycles");

  a_id_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    create_ok |=> (next_id_q == $past(next_id_q) + IdW'(1)))
    else $error("id counter did not advance on create");

  a_id_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !create_ok |=> $stable(next_id_q)) else $error("id counter moved without create");
`endif

endmodule

// ===== design/rht_cell.sv =====
// One slot of the handle table, as a cell of the command chain.
// Serves a passing command if no earlier cell did; depends on rht_pkg.
module rht_cell
  import rht_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [IdW-1:0] next_id_i,
  input  pkt_t           pkt_i,
  output pkt_t           pkt_o
);

  logic                active_q, active_d;
  logic [TypeW-1:0]    type_q, type_d;
  logic [IdW-1:0]      id_q, id_d;
  logic [CreatorW-1:0] creator_q, creator_d;
  logic [RefsW-1:0]    refs_q, refs_d;
  logic                hit;
  logic                is_create, is_attach, is_detach;
  pkt_t                pkt_d;

  assign is_create = (pkt_i.cmd == CmdCreate);
  assign is_attach = (pkt_i.cmd == CmdAttach);
  assign is_detach = (pkt_i.cmd == CmdDetach);

  // This slot serves the command: free slot for create, matching id otherwise
  assign hit = pkt_i.valid && !pkt_i.done &&
               ((is_create && !active_q) ||
                ((is_attach || is_detach) && active_q && (id_q == pkt_i.target_id)));

  // Slot update
  always_comb begin
    active_d  = active_q;
    type_d    = type_q;
    id_d      = id_q;
    creator_d = creator_q;
    refs_d    = refs_q;
    if (hit) begin
      if (is_create) begin
        active_d  = 1'b1;
        type_d    = pkt_i.ns_type;
        id_d      = next_id_i;
        creator_d = pkt_i.creator;
        refs_d    = RefsOne;
      end else if (is_attach) begin
        if (refs_q != RefsMax) refs_d = refs_q + RefsOne;
      end else begin
        if (refs_q <= RefsOne) begin
          refs_d   = '0;
          active_d = 1'b0;
        end else begin
          refs_d = refs_q - RefsOne;
        end
      end
    end
  end

  // Packet to the next cell
  always_comb begin
    pkt_d      = pkt_i;
    pkt_d.done = pkt_i.done | hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pkt_o    <= '0;
    end else begin
      active_q <= active_d;
      pkt_o    <= pkt_d;
    end
  end

  // Payload, no reset needed: read only while the slot is active
  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    id_q      <= id_d;
    creator_q <= creator_d;
    refs_q    <= refs_d;
  end

endmodule

// ===== bench/tb_refcounted_handle_table.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the reference-counted handle table: directed rows, then random
// command traffic and a reference-stacking run, scored against an in-bench model of the slot table.
// Depends on rht_pkg and refcounted_handle_table.
module tb_refcounted_handle_table;
  import rht_pkg::*;

  localparam int unsigned Entries     = DefaultEntries;
  localparam int          RandomItems = 1600;
  localparam int          StallLimit  = 1000;
  localparam int          StackRefs   = 12;

  // cmd 3 is not decoded by the table
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic                status;
    logic [IdW-1:0]      new_id;
  } answer_t;

  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic [TypeW-1:0]    ns_type;
    logic [CreatorW-1:0] creator;
    logic [IdW-1:0]      target_id;
    logic                typed;     // answer below is fixed by hand
    logic                status;
    logic [IdW-1:0]      new_id;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CmdW-1:0]     cmd_i;
  logic [TypeW-1:0]    ns_type_i;
  logic [CreatorW-1:0] creator_i;
  logic [IdW-1:0]      target_id_i;
  logic                result_valid_o;
  logic                status_o;
  logic [IdW-1:0]      new_id_o;

  // hand-typed answer that travels with the command being driven
  logic                row_typed;
  logic                row_status;
  logic [IdW-1:0]      row_new_id;

  // model of the slot table
  logic                slot_live    [Entries];
  logic [TypeW-1:0]    slot_type    [Entries];
  logic [IdW-1:0]      slot_id      [Entries];
  logic [CreatorW-1:0] slot_creator [Entries];
  logic [RefsW-1:0]    slot_refs    [Entries];
  logic [IdW-1:0]      id_counter;

  answer_t answers_due[$];
  row_t    plan[$];
  int      mismatches;
  int      idle_cycles;
  bit      idle_on;

  refcounted_handle_table #(
    .TABLE_ENTRIES(Entries)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .ns_type_i     (ns_type_i),
    .creator_i     (creator_i),
    .target_id_i   (target_id_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .new_id_o      (new_id_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one command to the model and return its answer
  task automatic table_apply(input logic [CmdW-1:0] cmd, input logic [TypeW-1:0] ty,
                             input logic [CreatorW-1:0] who, input logic [IdW-1:0] tid,
                             output logic st, output logic [IdW-1:0] nid);
    int hit;
    int k;
    begin
      st  = 1'b1;
      nid = '0;
      hit = -1;
      case (cmd)
        CmdCreate: begin
          for (k = 0; k < Entries; k++)
            if (!slot_live[k] && hit < 0) hit = k;
          if (hit >= 0) begin
            slot_live[hit]    = 1'b1;
            slot_type[hit]    = ty;
            slot_id[hit]      = id_counter;
            slot_creator[hit] = who;
            slot_refs[hit]    = RefsOne;
            nid               = id_counter;
            id_counter        = id_counter + 1'b1;
            st                = 1'b0;
          end
        end
        CmdAttach, CmdDetach: begin
          for (k = 0; k < Entries; k++)
            if (slot_live[k] && slot_id[k] == tid && hit < 0) hit = k;
          if (hit >= 0) begin
            st = 1'b0;
            if (cmd == CmdAttach) begin
              if (slot_refs[hit] != RefsMax) slot_refs[hit] = slot_refs[hit] + 1'b1;
            end else if (slot_refs[hit] <= RefsOne) begin
              slot_refs[hit] = '0;
              slot_live[hit] = 1'b0;
            end else begin
              slot_refs[hit] = slot_refs[hit] - 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  // Mostly a live id, otherwise a stray or near-miss value
  function automatic logic [IdW-1:0] choose_target();
    int live_n;
    int pick;
    int k;
    logic [IdW-1:0] tid;
    begin
      live_n = 0;
      for (k = 0; k < Entries; k++)
        if (slot_live[k]) live_n++;
      if (live_n > 0 && $urandom_range(99) < 85) begin
        pick = $urandom_range(live_n - 1);
        tid  = '0;
        for (k = 0; k < Entries; k++)
          if (slot_live[k]) begin
            if (pick == 0) tid = slot_id[k];
            pick--;
          end
      end else if ($urandom_range(1) == 0) begin
        tid = $urandom;
      end else begin
        tid = $urandom_range(id_counter + 32'd2);
      end
      return tid;
    end
  endfunction

  task automatic add_row(input logic [CmdW-1:0] cmd, input logic [TypeW-1:0] ty,
                         input logic [CreatorW-1:0] who, input logic [IdW-1:0] tid,
                         input logic typed, input logic st, input logic [IdW-1:0] nid);
    row_t r;
    begin
      r.cmd       = cmd;
      r.ns_type   = ty;
      r.creator   = who;
      r.target_id = tid;
      r.typed     = typed;
      r.status    = st;
      r.new_id    = nid;
      plan.push_back(r);
    end
  endtask

  // Drive one command, entered at a falling edge; returns at the accepting rising edge
  task automatic send(input logic [CmdW-1:0] cmd, input logic [TypeW-1:0] ty,
                      input logic [CreatorW-1:0] who, input logic [IdW-1:0] tid,
                      input logic typed, input logic st, input logic [IdW-1:0] nid);
    int  gap;
    bit  accepted;
    begin
      gap      = (idle_on && $urandom_range(99) < 3) ? $urandom_range(1, 40) : 0;
      accepted = 1'b0;
      while (!accepted) begin
        if (gap != 0 || (idle_on && $urandom_range(99) < 8)) begin
          if (gap != 0) gap--;
          start_i <= 1'b0;
        end else begin
          start_i     <= 1'b1;
          cmd_i       <= cmd;
          ns_type_i   <= ty;
          creator_i   <= who;
          target_id_i <= tid;
          row_typed   <= typed;
          row_status  <= st;
          row_new_id  <= nid;
        end
        @(posedge clk_i);
        accepted = start_i && !busy_o;
        if (!accepted) @(negedge clk_i);
      end
    end
  endtask

  // Hold off at a falling edge until every answer is in; ends at a falling edge
  task automatic drain();
    begin
      start_i <= 1'b0;
      while (answers_due.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end
  endtask

  // Score results, then record the transfer taken at this edge
  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    logic    st;
    logic [IdW-1:0] nid;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.status = status_o;
        got.new_id = new_id_o;
        if (answers_due.size() == 0) begin
          $error("result with no command outstanding: status %0d new_id %0h",
                 got.status, got.new_id);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.new_id !== want.new_id) begin
            $error("new_id: expected %0h, got %0h", want.new_id, got.new_id);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) begin
        table_apply(cmd_i, ns_type_i, creator_i, target_id_i, st, nid);
        if (row_typed) begin
          want.status = row_status;
          want.new_id = row_new_id;
        end else begin
          want.status = st;
          want.new_id = nid;
        end
        answers_due.push_back(want);
      end
    end
  end

  // Watchdog: too long with no transfer on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || result_valid_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[refcounted_handle_table] ERROR");
    $finish;
  end

  initial begin
    int             n;
    int             k;
    int             create_w;
    int             r;
    int             free_slot;
    row_t           row;
    logic [CmdW-1:0] cmd;
    logic [IdW-1:0] sat_id;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = CmdCreate;
    ns_type_i   = '0;
    creator_i   = '0;
    target_id_i = '0;
    row_typed   = 1'b0;
    row_status  = 1'b0;
    row_new_id  = '0;
    mismatches  = 0;
    idle_on     = 1'b1;
    create_w    = 45;
    for (k = 0; k < Entries; k++) begin
      slot_live[k]    = 1'b0;
      slot_type[k]    = '0;
      slot_id[k]      = '0;
      slot_creator[k] = '0;
      slot_refs[k]    = '0;
    end
    id_counter = 32'd1;

    // Directed rows: field extremes, misses, unused code, fill to full and reuse
    add_row(CmdCreate, 5'd0,  16'h0000, 32'h0,        1, 1'b0, 32'd1);
    add_row(CmdCreate, 5'd31, 16'hFFFF, 32'hFFFFFFFF, 1, 1'b0, 32'd2);
    add_row(CmdAttach, 5'd31, 16'hFFFF, 32'd1,        1, 1'b0, 32'd0);
    add_row(CmdDetach, 5'd0,  16'h0000, 32'd2,        1, 1'b0, 32'd0);
    add_row(CmdDetach, 5'd0,  16'h0000, 32'd2,        1, 1'b1, 32'd0);
    add_row(CmdAttach, 5'd0,  16'h0000, 32'hFFFFFFFF, 1, 1'b1, 32'd0);
    add_row(CmdAttach, 5'd0,  16'h0000, 32'h0,        1, 1'b1, 32'd0);
    add_row(CmdUnused, 5'd31, 16'hFFFF, 32'd1,        1, 1'b1, 32'd0);
    add_row(CmdCreate, 5'h15, 16'hA5A5, 32'h5A5A5A5A, 1, 1'b0, 32'd3);
    for (k = 0; k < Entries - 2; k++)
      add_row(CmdCreate, 5'($urandom), 16'($urandom), $urandom, 0, 1'b0, 32'd0);
    // full table, then id 1 still held by its second reference
    add_row(CmdCreate, 5'd7,  16'h1234, 32'd0,        1, 1'b1, 32'd0);
    add_row(CmdDetach, 5'd0,  16'h0000, 32'd1,        1, 1'b0, 32'd0);
    add_row(CmdCreate, 5'd7,  16'h1234, 32'd0,        1, 1'b1, 32'd0);
    add_row(CmdDetach, 5'd0,  16'h0000, 32'd1,        1, 1'b0, 32'd0);
    add_row(CmdCreate, 5'd9,  16'h8001, 32'd0,        0, 1'b0, 32'd0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      row = plan[i];
      @(negedge clk_i);
      send(row.cmd, row.ns_type, row.creator, row.target_id,
           row.typed, row.status, row.new_id);
    end
    @(negedge clk_i);
    drain();

    // Random traffic in phases that lean toward filling or emptying the table
    for (n = 0; n < RandomItems; n++) begin
      if (n % 200 == 0) begin
        case ($urandom_range(2))
          0:       create_w = 15;
          1:       create_w = 45;
          default: create_w = 75;
        endcase
      end
      idle_on = !(n >= 600 && n < 1000);
      @(negedge clk_i);
      if (n == 800 || $urandom_range(99) == 0) drain();
      r = $urandom_range(99);
      if (r < create_w) cmd = CmdCreate;
      else if (r < create_w + (95 - create_w) / 2) cmd = CmdAttach;
      else if (r < 95) cmd = CmdDetach;
      else cmd = CmdUnused;
      send(cmd, 5'($urandom_range(31)), 16'($urandom_range(16'hFFFF)), choose_target(),
           1'b0, 1'b0, '0);
    end

    // Stack references on one entry, then step it down and back up
    @(negedge clk_i);
    drain();
    free_slot = -1;
    for (k = 0; k < Entries; k++)
      if (!slot_live[k] && free_slot < 0) free_slot = k;
    if (free_slot >= 0) begin
      sat_id = id_counter;
      send(CmdCreate, 5'd31, 16'hFFFF, 32'd0, 1'b0, 1'b0, '0);
      @(negedge clk_i);
    end else begin
      sat_id = slot_id[0];
    end
    for (n = 0; n < StackRefs; n++) begin
      send(CmdAttach, 5'($urandom), 16'($urandom), sat_id, 1'b0, 1'b0, '0);
      @(negedge clk_i);
    end
    send(CmdDetach, 5'd0, 16'd0, sat_id, 1'b0, 1'b0, '0);
    @(negedge clk_i);
    send(CmdAttach, 5'd0, 16'd0, sat_id, 1'b0, 1'b0, '0);
    @(negedge clk_i);
    send(CmdAttach, 5'd0, 16'd0, sat_id, 1'b0, 1'b0, '0);

    // Wind down
    @(negedge clk_i);
    start_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (Entries + 4) @(posedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("[refcounted_handle_table] OK");
    end else begin
      $display("[refcounted_handle_table] ERROR");
    end
    $finish;
  end

endmodule
